@@ design/ddarc_pkg.sv @@
// Shared types and constants for the DDA column raycaster.
`timescale 1ns / 1ps
package ddarc_pkg;

    localparam int DELTA_W = 24;
    localparam logic [DELTA_W-1:0] DELTA_MAX = 24'hFFFFFF;
    // side distances grow by up to 2*MAP_SIZE+2 steps of delta
    localparam int SIDE_W = 32;

    typedef enum logic [2:0] {
        REG_POS_X   = 3'd0,
        REG_POS_Y   = 3'd1,
        REG_DIR_X   = 3'd2,
        REG_DIR_Y   = 3'd3,
        REG_PLANE_X = 3'd4,
        REG_PLANE_Y = 3'd5,
        REG_SCR_W   = 3'd6,
        REG_SCR_H   = 3'd7
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MULX,
        ST_MULY,
        ST_DIVX,
        ST_DIVY,
        ST_SIDE,
        ST_WALK,
        ST_PROBE,
        ST_DIVH,
        ST_FINISH,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic       start;
        logic [63:0] num;
        logic [31:0] den;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] quot;
    } div_rsp_t;

endpackage

@@ design/ddarc_if.sv @@
// Valid/ready channel interfaces for the raycaster.
`timescale 1ns / 1ps
interface ddarc_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [10:0] column;
    logic [3:0]  cell_row;
    logic [3:0]  cell_col;
    logic        wall;
    modport source (output valid, action, column, cell_row, cell_col, wall, input ready);
    modport sink (input valid, action, column, cell_row, cell_col, wall, output ready);
endinterface

interface ddarc_out_if;
    logic        valid;
    logic        ready;
    logic [10:0] column_out;
    logic [10:0] draw_start;
    logic [10:0] draw_end;
    logic        side;
    logic [3:0]  hit_col;
    logic [3:0]  hit_row;
    logic        escaped;
    modport source (output valid, column_out, draw_start, draw_end, side, hit_col, hit_row,
                    escaped, input ready);
    modport sink (input valid, column_out, draw_start, draw_end, side, hit_col, hit_row,
                  escaped, output ready);
endinterface

interface ddarc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ design/ddarc_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module ddarc_div
    import ddarc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [63:0] quot_reg, quot_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] den_reg, den_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = '0;
        if (req.start)
        begin
            quot_next = req.num;
            rem_next  = '0;
            den_next  = req.den;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            trial = {rem_reg[31:0], quot_reg[63]};
            quot_next = {quot_reg[62:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                rem_next     = trial - {1'b0, den_reg};
                quot_next[0] = 1'b1;
            end
            else
                rem_next = trial;
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> $past(busy_reg)) else $error("divider done without work");
    a_cnt_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg && !req.start |=> !busy_reg) else $error("divider woke by itself");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |=> busy_reg) else $error("divider start lost");

endmodule

@@ design/dda_column_raycaster_core.sv @@
// Top level of the DDA column raycaster: map store, sequencer, output register.
`timescale 1ns / 1ps
// Usage:
//   cfg  : write channel, index 0..7 = pos_x, pos_y, dir_x, dir_y, plane_x,
//          plane_y, view width, view height. Write only while idle.
//   in   : one transaction either writes a map cell (action 0, no result)
//          or casts the ray of one screen column (action 1, one result).
//   out  : one transaction per cast, held until the receiver takes it.
// Sequence: a cell write is taken in idle and leaves in.ready high. A cast
//   runs the two products, two runs of the shared divider for the ray
//   deltas, side setup, then per grid step a walk state and a registered
//   map read, a third divider run for the slice height on a hit with
//   nonzero distance, and the clamp. A ray that leaves the map, hits the
//   step limit or starts from a camera outside the map skips the height
//   division. One item at a time: in.ready is low from acceptance of a cast
//   until its result is taken.
// Reset: registers take their reset values, then a clearing pass over all
//   MAP_SIZE*MAP_SIZE cells loads border walls and an empty interior;
//   in.ready stays low during the pass.
// Stall: while out.valid waits on out.ready the block holds the result and
//   accepts nothing on the in channel.
module dda_column_raycaster_core
    import ddarc_pkg::*;
#(
    parameter int MAP_SIZE = 16
)
(
    input  logic clk,
    input  logic rst_n,
    ddarc_cfg_if.sink   cfg,
    ddarc_in_if.sink    in,
    ddarc_out_if.source out
);

    localparam int MW = $clog2(MAP_SIZE);
    localparam int MC = MW + 2; // signed cell coordinate with room to step off
    localparam int GUARD = 2 * MAP_SIZE + 2;
    localparam int GW = $clog2(GUARD + 1);
    localparam int CELLS = MAP_SIZE * MAP_SIZE;
    localparam int AW = $clog2(CELLS);

    function automatic logic [AW-1:0] cell_addr(input logic [MW-1:0] r,
                                                 input logic [MW-1:0] c);
        return AW'(r) * AW'(MAP_SIZE) + AW'(c);
    endfunction

    logic [15:0] pos_x_reg, pos_y_reg;
    logic signed [15:0] dir_x_reg, dir_y_reg, plane_x_reg, plane_y_reg;
    logic [10:0] scr_w_reg, scr_h_reg;

    logic map_mem [CELLS];
    logic map_rd_reg;
    logic [MW-1:0] clr_row_reg, clr_col_reg;
    logic clr_last, clr_border;

    state_t state_reg, state_next;
    logic [10:0] col_reg;
    logic signed [29:0] nx_reg, ny_reg;
    logic [DELTA_W-1:0] dx_reg, dy_reg;
    logic [SIDE_W-1:0] sdx_reg, sdy_reg;
    logic signed [MC-1:0] mx_reg, my_reg;
    logic side_reg, esc_reg;
    logic [GW-1:0] guard_reg;
    logic [10:0] ds_reg, de_reg;
    logic [15:0] height_reg;
    logic out_valid_reg;
    logic side_phase_reg;

    div_req_t dreq;
    div_rsp_t drsp;

    ddarc_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    logic [10:0] w_eff;
    assign w_eff = (scr_w_reg == 11'd0) ? 11'd1 : scr_w_reg;

    logic signed [12:0] cam;
    assign cam = $signed({1'b0, col_reg, 1'b0}) - $signed({2'b00, w_eff});

    // single shared multiplier pair selected by phase
    logic signed [15:0] m_dir, m_plane;
    logic signed [29:0] n_sum;
    assign m_dir   = (state_reg == ST_MULX) ? dir_x_reg : dir_y_reg;
    assign m_plane = (state_reg == ST_MULX) ? plane_x_reg : plane_y_reg;
    assign n_sum = 30'(m_dir) * 30'($signed({1'b0, w_eff})) + 30'(m_plane) * 30'(cam);

    logic signed [29:0] n_sel;
    logic [29:0] nx_abs, ny_abs;
    assign n_sel  = (state_reg == ST_DIVX) ? nx_reg : ny_reg;
    assign nx_abs = nx_reg[29] ? 30'(-nx_reg) : 30'(nx_reg);
    assign ny_abs = ny_reg[29] ? 30'(-ny_reg) : 30'(ny_reg);

    logic [DELTA_W-1:0] delta_sat;
    assign delta_sat = (n_sel == '0 || drsp.quot[63:DELTA_W] != '0) ? DELTA_MAX
                       : drsp.quot[DELTA_W-1:0];

    // side distance init: one 13x24 product per side phase
    logic [11:0] f_sel;
    logic [12:0] fm;
    logic [DELTA_W-1:0] d_sel;
    logic [36:0] sprod;
    logic neg_sel;
    assign f_sel   = side_phase_reg ? pos_y_reg[11:0] : pos_x_reg[11:0];
    assign neg_sel = side_phase_reg ? ny_reg[29] : nx_reg[29];
    assign d_sel   = side_phase_reg ? dy_reg : dx_reg;
    assign fm      = neg_sel ? {1'b0, f_sel} : 13'd4096 - {1'b0, f_sel};
    assign sprod   = fm * d_sel;

    logic step_x;
    logic signed [MC-1:0] nmx, nmy;
    logic [SIDE_W-1:0] nsdx, nsdy;
    logic off_map, walk_go;
    logic [MW-1:0] rx, ry;
    assign step_x = sdx_reg < sdy_reg;
    assign nmx  = step_x ? (nx_reg[29] ? mx_reg - MC'(1) : mx_reg + MC'(1)) : mx_reg;
    assign nmy  = step_x ? my_reg : (ny_reg[29] ? my_reg - MC'(1) : my_reg + MC'(1));
    assign nsdx = step_x ? sdx_reg + SIDE_W'(dx_reg) : sdx_reg;
    assign nsdy = step_x ? sdy_reg : sdy_reg + SIDE_W'(dy_reg);
    assign off_map = nmx < 0 || nmy < 0 || nmx >= MC'(MAP_SIZE) || nmy >= MC'(MAP_SIZE);
    assign rx = nmx[MW-1:0];
    assign ry = nmy[MW-1:0];
    assign walk_go = (state_reg == ST_WALK) && !esc_reg && guard_reg != GW'(GUARD);

    logic [SIDE_W-1:0] perp;
    assign perp = side_reg ? sdy_reg - SIDE_W'(dy_reg) : sdx_reg - SIDE_W'(dx_reg);

    logic [15:0] height_sel;
    logic [10:0] half_h;
    logic [14:0] half_ht;
    logic signed [17:0] ds_s, de_s;
    assign height_sel = drsp.quot[63:16] != '0 ? 16'hFFFF : drsp.quot[15:0];
    assign half_h  = scr_h_reg >> 1;
    assign half_ht = height_reg[15:1];
    assign ds_s = $signed({7'd0, half_h}) - $signed({3'd0, half_ht});
    assign de_s = $signed({7'd0, half_h}) + $signed({3'd0, half_ht});

    assign clr_last = clr_row_reg == MW'(MAP_SIZE - 1) && clr_col_reg == MW'(MAP_SIZE - 1);
    assign clr_border = clr_row_reg == '0 || clr_col_reg == '0
                        || clr_row_reg == MW'(MAP_SIZE - 1) || clr_col_reg == MW'(MAP_SIZE - 1);

    logic in_acc, cfg_acc, map_we;
    assign in.ready  = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;
    assign in_acc  = in.valid && in.ready;
    assign cfg_acc = cfg.valid && cfg.ready;
    assign map_we  = in_acc && !in.action && 32'(in.cell_row) < MAP_SIZE
                     && 32'(in.cell_col) < MAP_SIZE;

    always_comb
    begin
        state_next = state_reg;
        dreq = '0;
        case (state_reg)
            ST_CLEAR:
                if (clr_last)
                    state_next = ST_IDLE;
            ST_IDLE:
                if (in_acc && in.action)
                    state_next = ST_MULX;
            ST_MULX:
                state_next = ST_MULY;
            ST_MULY:
            begin
                dreq.start = 1'b1;
                dreq.num = 64'({w_eff, 30'd0});
                dreq.den = 32'(nx_abs == '0 ? 30'd1 : nx_abs);
                state_next = ST_DIVX;
            end
            ST_DIVX:
                if (drsp.done)
                begin
                    dreq.start = 1'b1;
                    dreq.num = 64'({w_eff, 30'd0});
                    dreq.den = 32'(ny_abs == '0 ? 30'd1 : ny_abs);
                    state_next = ST_DIVY;
                end
            ST_DIVY:
                if (drsp.done)
                    state_next = ST_SIDE;
            ST_SIDE:
                if (side_phase_reg)
                    state_next = ST_WALK;
            ST_WALK:
                if (!walk_go || off_map)
                    state_next = ST_FINISH;
                else
                    state_next = ST_PROBE;
            ST_PROBE:
                if (!map_rd_reg)
                    state_next = ST_WALK;
                else if (perp == '0)
                    state_next = ST_FINISH;
                else
                begin
                    dreq.start = 1'b1;
                    dreq.num = 64'({scr_h_reg, 16'd0});
                    dreq.den = perp;
                    state_next = ST_DIVH;
                end
            ST_DIVH:
                if (drsp.done)
                    state_next = ST_FINISH;
            ST_FINISH:
                state_next = ST_OUT;
            ST_OUT:
                if (out.ready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            out_valid_reg <= 1'b0;
            pos_x_reg <= 16'd30720;
            pos_y_reg <= 16'd30720;
            dir_x_reg <= 16'sd16384;
            dir_y_reg <= 16'sd0;
            plane_x_reg <= 16'sd0;
            plane_y_reg <= 16'sd10813;
            scr_w_reg <= 11'd1200;
            scr_h_reg <= 11'd900;
            clr_row_reg <= '0;
            clr_col_reg <= '0;
            side_phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= (state_next == ST_OUT);
            if (cfg_acc)
            begin
                case (cfg_reg_t'(cfg.index))
                    REG_POS_X:   pos_x_reg <= cfg.data;
                    REG_POS_Y:   pos_y_reg <= cfg.data;
                    REG_DIR_X:   dir_x_reg <= cfg.data;
                    REG_DIR_Y:   dir_y_reg <= cfg.data;
                    REG_PLANE_X: plane_x_reg <= cfg.data;
                    REG_PLANE_Y: plane_y_reg <= cfg.data;
                    REG_SCR_W:   scr_w_reg <= cfg.data[10:0];
                    REG_SCR_H:   scr_h_reg <= cfg.data[10:0];
                    default: ;
                endcase
            end
            if (state_reg == ST_CLEAR)
            begin
                if (clr_col_reg == MW'(MAP_SIZE - 1))
                begin
                    clr_col_reg <= '0;
                    clr_row_reg <= clr_row_reg + MW'(1);
                end
                else
                    clr_col_reg <= clr_col_reg + MW'(1);
            end
            if (state_reg == ST_SIDE)
                side_phase_reg <= !side_phase_reg;
        end
    end

    // wall map: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
            map_mem[cell_addr(clr_row_reg, clr_col_reg)] <= clr_border;
        else if (map_we)
            map_mem[cell_addr(MW'(in.cell_row), MW'(in.cell_col))] <= in.wall;
        if (walk_go && !off_map)
            map_rd_reg <= map_mem[cell_addr(ry, rx)];
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                col_reg <= in.column;
                guard_reg <= '0;
                side_reg <= 1'b0;
            end
            ST_MULX: nx_reg <= n_sum;
            ST_MULY: ny_reg <= n_sum;
            ST_DIVX: if (drsp.done) dx_reg <= delta_sat;
            ST_DIVY: if (drsp.done) dy_reg <= delta_sat;
            ST_SIDE:
            begin
                if (side_phase_reg)
                    sdy_reg <= SIDE_W'(sprod >> 12);
                else
                    sdx_reg <= SIDE_W'(sprod >> 12);
                mx_reg <= MC'({2'b00, pos_x_reg[15:12]});
                my_reg <= MC'({2'b00, pos_y_reg[15:12]});
                esc_reg <= (32'(pos_x_reg[15:12]) >= MAP_SIZE)
                           || (32'(pos_y_reg[15:12]) >= MAP_SIZE);
            end
            ST_WALK:
                if (walk_go)
                begin
                    sdx_reg <= nsdx;
                    sdy_reg <= nsdy;
                    mx_reg <= nmx;
                    my_reg <= nmy;
                    side_reg <= !step_x;
                    guard_reg <= guard_reg + GW'(1);
                    if (off_map)
                        esc_reg <= 1'b1;
                end
                else
                    esc_reg <= 1'b1;
            ST_PROBE:
                if (map_rd_reg && perp == '0)
                    height_reg <= 16'(scr_h_reg);
            ST_DIVH:
                if (drsp.done)
                    height_reg <= height_sel;
            ST_FINISH:
            begin
                ds_reg <= ds_s < 0 ? 11'd0 : 11'(ds_s);
                if (scr_h_reg == 11'd0)
                    de_reg <= 11'd0;
                else if (de_s > $signed({7'd0, scr_h_reg}) - 18'sd1)
                    de_reg <= scr_h_reg - 11'd1;
                else
                    de_reg <= 11'(de_s);
            end
            default: ;
        endcase
    end

    assign out.valid      = out_valid_reg;
    assign out.column_out = col_reg;
    assign out.escaped    = esc_reg;
    assign out.draw_start = esc_reg ? 11'd0 : ds_reg;
    assign out.draw_end   = esc_reg ? 11'd0 : de_reg;
    assign out.side       = esc_reg ? 1'b0 : side_reg;
    assign out.hit_col    = esc_reg ? 4'd0 : 4'(mx_reg);
    assign out.hit_row    = esc_reg ? 4'd0 : 4'(my_reg);

    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out.valid |-> !in.ready) else $error("ready while result pending");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out.valid && !out.ready |=> out.valid) else $error("result dropped");
    a_guard_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WALK |-> guard_reg <= GW'(GUARD)) else $error("walk overran");

endmodule

@@ tb/dda_column_raycaster_core_tb.sv @@
// Self-checking testbench for the DDA column raycaster core.
`timescale 1ns / 1ps
module dda_column_raycaster_core_tb
    import ddarc_pkg::*;
;

    localparam int MAP_N = 16;

    typedef struct packed {
        logic        action;
        logic [10:0] column;
        logic [3:0]  cell_row;
        logic [3:0]  cell_col;
        logic        wall;
    } cast_req_t;

    typedef struct packed {
        logic [10:0] column_out;
        logic [10:0] draw_start;
        logic [10:0] draw_end;
        logic        side;
        logic [3:0]  hit_col;
        logic [3:0]  hit_row;
        logic        escaped;
    } slice_t;

    logic clk;
    logic rst_n;

    ddarc_cfg_if cfg_ch();
    ddarc_in_if  in_ch();
    ddarc_out_if out_ch();

    dda_column_raycaster_core #(.MAP_SIZE(MAP_N)) i_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch.sink),
        .in    (in_ch.sink),
        .out   (out_ch.source)
    );

    // predictor state
    logic [15:0] m_pos_x, m_pos_y, m_dir_x, m_dir_y, m_plane_x, m_plane_y;
    logic [10:0] m_width, m_height;
    logic        m_map [MAP_N*MAP_N];

    cast_req_t pending_items[$];
    slice_t    expected_slices[$];
    int        errors;
    int        send_idle_pct;
    int        recv_stall_pct;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("FAILURE");
        $finish;
    end

    task automatic model_reset();
        m_pos_x = 16'd30720;
        m_pos_y = 16'd30720;
        m_dir_x = 16'd16384;
        m_dir_y = 16'd0;
        m_plane_x = 16'd0;
        m_plane_y = 16'd10813;
        m_width = 11'd1200;
        m_height = 11'd900;
        for (int r = 0; r < MAP_N; r++)
            for (int c = 0; c < MAP_N; c++)
                m_map[r*MAP_N+c] = (r == 0 || c == 0 || r == MAP_N-1 || c == MAP_N-1);
    endtask

    function automatic longint ray_delta(longint n, longint w);
        longint m;
        longint d;
        if (n == 0)
            return longint'(DELTA_MAX);
        m = (n < 0) ? -n : n;
        d = (w << 30) / m;
        return (d > longint'(DELTA_MAX)) ? longint'(DELTA_MAX) : d;
    endfunction

    // DDA walk and slice computation for one column
    function automatic slice_t cast_column(logic [10:0] col);
        slice_t  s;
        longint  w, h, cam, nx, ny, dx, dy, sdx, sdy, fx, fy, perp, ht, half, ds, de;
        longint  mx, my, stx, sty;
        bit      side, esc;
        w = (m_width == 0) ? 1 : longint'(m_width);
        h = longint'(m_height);
        cam = 2*longint'(col) - w;
        nx = longint'($signed(m_dir_x))*w + longint'($signed(m_plane_x))*cam;
        ny = longint'($signed(m_dir_y))*w + longint'($signed(m_plane_y))*cam;
        dx = ray_delta(nx, w);
        dy = ray_delta(ny, w);
        mx = longint'(m_pos_x >> 12);
        my = longint'(m_pos_y >> 12);
        fx = longint'(m_pos_x & 16'hFFF);
        fy = longint'(m_pos_y & 16'hFFF);
        if (nx < 0) begin stx = -1; sdx = (fx*dx) >>> 12; end
        else begin stx = 1; sdx = ((4096-fx)*dx) >>> 12; end
        if (ny < 0) begin sty = -1; sdy = (fy*dy) >>> 12; end
        else begin sty = 1; sdy = ((4096-fy)*dy) >>> 12; end
        side = 0;
        esc = 1;
        if (mx < MAP_N && my < MAP_N)
        begin
            for (int g = 0; g < 2*MAP_N+2; g++)
            begin
                if (sdx < sdy) begin sdx += dx; mx += stx; side = 0; end
                else begin sdy += dy; my += sty; side = 1; end
                if (mx < 0 || my < 0 || mx >= MAP_N || my >= MAP_N)
                    break;
                if (m_map[my*MAP_N+mx]) begin esc = 0; break; end
            end
        end
        s = '0;
        s.column_out = col;
        s.escaped = esc;
        if (!esc)
        begin
            perp = side ? sdy - dy : sdx - dx;
            ht = (perp != 0) ? (h << 16) / perp : h;
            half = h / 2;
            ds = half - ht/2;
            de = half + ht/2;
            if (ds < 0) ds = 0;
            if (h == 0) de = 0;
            else if (de > h-1) de = h-1;
            s.draw_start = ds[10:0];
            s.draw_end = de[10:0];
            s.side = side;
            s.hit_col = mx[3:0];
            s.hit_row = my[3:0];
        end
        return s;
    endfunction

    function automatic cast_req_t make_cast(logic [10:0] col);
        cast_req_t t;
        t = '0;
        t.action = 1'b1;
        t.column = col;
        t.cell_row = 4'($urandom);
        t.cell_col = 4'($urandom);
        t.wall = 1'($urandom);
        return t;
    endfunction

    function automatic cast_req_t make_write(logic [3:0] r, logic [3:0] c, logic v);
        cast_req_t t;
        t.action = 1'b0;
        t.column = 11'($urandom);
        t.cell_row = r;
        t.cell_col = c;
        t.wall = v;
        return t;
    endfunction

    // driver: input channel
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            {in_ch.action, in_ch.column, in_ch.cell_row, in_ch.cell_col, in_ch.wall} <= '0;
        end
        else if (!in_ch.valid || in_ch.ready)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                cast_req_t acc;
                acc = {in_ch.action, in_ch.column, in_ch.cell_row, in_ch.cell_col, in_ch.wall};
                if (acc.action)
                    expected_slices.push_back(cast_column(acc.column));
                else
                    m_map[acc.cell_row*MAP_N+acc.cell_col] = acc.wall;
            end
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                cast_req_t nx;
                nx = pending_items.pop_front();
                in_ch.valid <= 1'b1;
                {in_ch.action, in_ch.column, in_ch.cell_row, in_ch.cell_col, in_ch.wall} <= nx;
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // monitor: output channel
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                slice_t got, exp_s;
                got = {out_ch.column_out, out_ch.draw_start, out_ch.draw_end, out_ch.side,
                       out_ch.hit_col, out_ch.hit_row, out_ch.escaped};
                if (expected_slices.size() == 0)
                begin
                    $error("unexpected result column_out=%0d", got.column_out);
                    errors++;
                end
                else
                begin
                    exp_s = expected_slices.pop_front();
                    if (got.column_out !== exp_s.column_out) begin
                        $error("column_out exp %0d got %0d", exp_s.column_out, got.column_out);
                        errors++; end
                    if (got.draw_start !== exp_s.draw_start) begin
                        $error("draw_start exp %0d got %0d", exp_s.draw_start, got.draw_start);
                        errors++; end
                    if (got.draw_end !== exp_s.draw_end) begin
                        $error("draw_end exp %0d got %0d", exp_s.draw_end, got.draw_end);
                        errors++; end
                    if (got.side !== exp_s.side) begin
                        $error("side exp %0d got %0d", exp_s.side, got.side);
                        errors++; end
                    if (got.hit_col !== exp_s.hit_col) begin
                        $error("hit_col exp %0d got %0d", exp_s.hit_col, got.hit_col);
                        errors++; end
                    if (got.hit_row !== exp_s.hit_row) begin
                        $error("hit_row exp %0d got %0d", exp_s.hit_row, got.hit_row);
                        errors++; end
                    if (got.escaped !== exp_s.escaped) begin
                        $error("escaped exp %0d got %0d", exp_s.escaped, got.escaped);
                        errors++; end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        case (idx)
            REG_POS_X:   m_pos_x = val;
            REG_POS_Y:   m_pos_y = val;
            REG_DIR_X:   m_dir_x = val;
            REG_DIR_Y:   m_dir_y = val;
            REG_PLANE_X: m_plane_x = val;
            REG_PLANE_Y: m_plane_y = val;
            REG_SCR_W:   m_width = val[10:0];
            default:     m_height = val[10:0];
        endcase
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || in_ch.valid || expected_slices.size() > 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    // a random well-formed camera: position inside the map, direction components within +/-16384
    task automatic random_camera();
        write_reg(REG_POS_X, 16'($urandom_range(16'hEFFF, 16'h1000)));
        write_reg(REG_POS_Y, 16'($urandom_range(16'hEFFF, 16'h1000)));
        write_reg(REG_DIR_X, 16'($urandom_range(32767) - 16384));
        write_reg(REG_DIR_Y, 16'($urandom_range(32767) - 16384));
        write_reg(REG_PLANE_X, 16'($urandom_range(21000) - 10500));
        write_reg(REG_PLANE_Y, 16'($urandom_range(21000) - 10500));
        write_reg(REG_SCR_W, 11'($urandom_range(2047, 1)));
        write_reg(REG_SCR_H, 11'($urandom_range(2047, 2)));
    endtask

    initial
    begin
        errors = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_POS_X;
        cfg_ch.data = '0;
        model_reset();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset camera, edge columns, out-of-range column, map writes
        pending_items.push_back(make_cast(11'd0));
        pending_items.push_back(make_cast(11'd600));
        pending_items.push_back(make_cast(11'd1199));
        pending_items.push_back(make_cast(11'd2047));
        pending_items.push_back(make_write(4'd7, 4'd9, 1'b1));
        pending_items.push_back(make_cast(11'd600));
        pending_items.push_back(make_write(4'd7, 4'd9, 1'b0));
        pending_items.push_back(make_write(4'd7, 4'd15, 1'b0));
        pending_items.push_back(make_cast(11'd600));
        pending_items.push_back(make_write(4'd7, 4'd15, 1'b1));
        pending_items.push_back(make_write(4'd15, 4'd15, 1'b1));
        pending_items.push_back(make_cast(11'd1));
        drain();

        // zero direction (both deltas saturate), zero width, zero height
        write_reg(REG_DIR_X, 16'h0000);
        write_reg(REG_PLANE_Y, 16'h0000);
        write_reg(REG_SCR_W, 11'd0);
        write_reg(REG_SCR_H, 11'd0);
        pending_items.push_back(make_cast(11'd0));
        pending_items.push_back(make_cast(11'd2047));
        drain();
        // extreme direction, camera on wall edge and in a border wall cell, max width/height
        write_reg(REG_DIR_X, 16'h8000);
        write_reg(REG_DIR_Y, 16'h7FFF);
        write_reg(REG_PLANE_X, 16'h7FFF);
        write_reg(REG_PLANE_Y, 16'h8000);
        write_reg(REG_SCR_W, 11'd2047);
        write_reg(REG_SCR_H, 11'd2047);
        write_reg(REG_POS_X, 16'h1000);
        write_reg(REG_POS_Y, 16'hFFFF);
        pending_items.push_back(make_cast(11'd1023));
        pending_items.push_back(make_cast(11'd0));
        drain();
        write_reg(REG_POS_Y, 16'h0000);
        write_reg(REG_SCR_H, 11'd2);
        write_reg(REG_SCR_W, 11'd1);
        pending_items.push_back(make_cast(11'd0));
        pending_items.push_back(make_cast(11'd1));
        drain();

        // random phases over several idle/stall mixes
        for (int ph = 0; ph < 12; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
                default: begin send_idle_pct = 27; recv_stall_pct = 27; end
            endcase
            if (ph == 11)
            begin
                // random noise config in every register
                for (int k = 0; k < 8; k++)
                    write_reg(cfg_reg_t'(k), 16'($urandom));
            end
            else
                random_camera();
            for (int k = 0; k < 125; k++)
            begin
                if ($urandom_range(99) < 25)
                    pending_items.push_back(make_write(4'($urandom), 4'($urandom),
                                                       1'($urandom_range(99) < 35)));
                else
                    pending_items.push_back(make_cast(($urandom_range(9) == 0) ?
                        11'($urandom) : 11'($urandom_range(m_width == 0 ? 0 : m_width - 1))));
            end
            drain();
        end

        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

@@ sim.f @@
design/ddarc_pkg.sv
design/ddarc_if.sv
design/ddarc_div.sv
design/dda_column_raycaster_core.sv
tb/dda_column_raycaster_core_tb.sv
